### rtl/ttbl_pkg.sv
package ttbl_pkg;

    localparam int TENANT_W   = 8;
    localparam int LEVEL_W    = 26;
    localparam int CAP_W      = 16;
    localparam int RATE_W     = 20;
    localparam int CONC_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // 1/1024 token fixed point
    localparam int TOKEN_SHIFT = 10;
    localparam logic [LEVEL_W-1:0] TOKEN_ONE = LEVEL_W'(1) << TOKEN_SHIFT;

    // elapsed ticks at or above this fill the bucket whenever the rate is nonzero
    localparam int SAT_SHIFT = 27;
    localparam int PROD_W    = SAT_SHIFT + RATE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONC = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RST = 16'd100;
    localparam logic [RATE_W-1:0] RATE_RST     = 20'd1024;
    localparam logic [CONC_W-1:0] MAX_CONC_RST = 16'd16;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAP       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic accept;     // latch request, start table read
        logic calc;       // elapsed time and refill product
        logic writeback;  // table update and result load
    } ctrl_cmd_t;

endpackage

### rtl/tenant_token_bucket_limiter.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tuser: cmd; tdata: tenant, now
// m_        out  m_tvalid/m_tready  tuser: status; tdata: tokens_left
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One request at a time: accept with table read, refill multiply,
// table writeback with result load. The next request is taken only after writeback.
// A finished result waits in the output register while the next request is
// taken; writeback holds only while that register is still full.
// Reset is synchronous, active low; it clears the tenant known bits at once.
module tenant_token_bucket_limiter #(
    parameter int TENANTS   = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] tenant, [8+TIME_BITS-1:8] now, zero pad to bytes
    input  logic [((8+TIME_BITS+7)/8)*8-1:0]    s_tdata,
    // [0] cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [25:0] tokens_left, zero pad
    output logic [31:0]                         m_tdata,
    // [1:0] status
    output logic [ttbl_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ttbl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ttbl_pkg::*;

    // only 2^TENANT_W tenants can ever be addressed
    localparam int DEPTH = (TENANTS < (1 << TENANT_W)) ? TENANTS : (1 << TENANT_W);

    ctrl_cmd_t            cmd;
    logic [LEVEL_W-1:0]   tokens;

    assign cfg_ready = 1'b1;

    ttbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ttbl_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_cmd     (s_tuser),
        .in_tenant  (s_tdata[TENANT_W-1:0]),
        .in_now     (s_tdata[TENANT_W+TIME_BITS-1:TENANT_W]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_status (m_tuser),
        .out_tokens (tokens)
    );

    assign m_tdata = {{(32-LEVEL_W){1'b0}}, tokens};

endmodule

### rtl/ttbl_ctrl.sv
module ttbl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ttbl_pkg::ctrl_cmd_t  cmd
);
    import ttbl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd.accept    = s_tvalid && s_tready;
        cmd.calc      = (state_reg == S_CALC);
        cmd.writeback = (state_reg == S_WB) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CALC;
            end
            S_CALC: state_next = S_WB;
            S_WB: begin
                // hold until the result slot can take the beat
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.writeback) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/ttbl_datapath.sv
module ttbl_datapath #(
    parameter int DEPTH     = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ttbl_pkg::ctrl_cmd_t            cmd,
    input  logic                           in_cmd,
    input  logic [ttbl_pkg::TENANT_W-1:0]  in_tenant,
    input  logic [TIME_BITS-1:0]           in_now,
    input  logic                           cfg_we,
    input  logic [ttbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttbl_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [ttbl_pkg::STATUS_W-1:0]  out_status,
    output logic [ttbl_pkg::LEVEL_W-1:0]   out_tokens
);
    import ttbl_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int ENTRY_W = LEVEL_W + TIME_BITS + CONC_W;
    localparam int SUM_W   = PROD_W + 1;
    // rounded-up reciprocal of the depth in 1/65536 units
    localparam int RECIP   = (65536 + DEPTH - 1) / DEPTH;

    // tenant modulo table depth: quotient by reciprocal multiply, exact for 8-bit tenants
    function automatic logic [IDX_W-1:0] tenant_index(input logic [TENANT_W-1:0] t);
        logic [31:0] prod;
        logic [15:0] quot;
        logic [15:0] r;
        prod = 32'(t) * 32'(RECIP);
        quot = 16'(prod >> 16);
        r    = 16'(t) - quot * 16'(DEPTH);
        return IDX_W'(r);
    endfunction

    // configuration
    logic [CAP_W-1:0]  cap_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [CONC_W-1:0] conc_reg;
    logic [LEVEL_W-1:0] cap_fp;

    assign cap_fp = {cap_reg, {TOKEN_SHIFT{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAPACITY_RST;
            rate_reg <= RATE_RST;
            conc_reg <= MAX_CONC_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg  <= cfg_data[CAP_W-1:0];
                CFG_RATE:     rate_reg <= cfg_data[RATE_W-1:0];
                CFG_MAX_CONC: conc_reg <= cfg_data[CONC_W-1:0];
                default: ;
            endcase
        end
    end

    // request latch and table
    logic               op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_reg;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;
    logic [DEPTH-1:0]   known_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= in_cmd;
            idx_reg <= tenant_index(in_tenant);
            now_reg <= in_now;
            rd_reg  <= mem[tenant_index(in_tenant)];
        end
        if (wr_en) mem[idx_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg <= '0;
        end else if (cmd.writeback && op_reg == CMD_ACQUIRE) begin
            known_reg[idx_reg] <= 1'b1;
        end
    end

    // calc stage
    logic [LEVEL_W-1:0]   rd_level;
    logic [TIME_BITS-1:0] rd_last;
    logic [CONC_W-1:0]    rd_inflight;
    logic                 hit;
    logic [LEVEL_W-1:0]   base_level;
    logic [TIME_BITS-1:0] base_last;
    logic [CONC_W-1:0]    base_inflight;
    logic [TIME_BITS-1:0] elapsed;
    logic [63:0]          elapsed_ext;

    assign {rd_level, rd_last, rd_inflight} = rd_reg;
    assign hit = known_reg[idx_reg];

    always_comb begin
        // new tenant starts full, stamped now, nothing in flight
        base_level    = hit ? rd_level : cap_fp;
        base_last     = hit ? rd_last : now_reg;
        base_inflight = hit ? rd_inflight : '0;
        elapsed       = now_reg - base_last;
        elapsed_ext   = 64'(elapsed);
    end

    logic                 hit_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [CONC_W-1:0]    inflight_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 sat_reg;
    logic                 refill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            hit_reg      <= hit;
            level_reg    <= base_level;
            last_reg     <= base_last;
            inflight_reg <= base_inflight;
            prod_reg     <= PROD_W'(elapsed_ext[SAT_SHIFT-1:0]) * PROD_W'(rate_reg);
            sat_reg      <= |elapsed_ext[63:SAT_SHIFT];
            refill_reg   <= (elapsed != '0) && (rate_reg != '0);
        end
    end

    // writeback stage
    logic [SUM_W-1:0]     sum;
    logic [LEVEL_W-1:0]   refilled;
    logic [TIME_BITS-1:0] new_last;
    logic [LEVEL_W-1:0]   new_level;
    logic [CONC_W-1:0]    new_inflight;
    logic [STATUS_W-1:0]  new_status;
    logic [LEVEL_W-1:0]   new_tokens;

    always_comb begin
        sum       = SUM_W'(level_reg) + SUM_W'(prod_reg);
        refilled  = level_reg;
        new_last  = last_reg;
        if (refill_reg) begin
            new_last = now_reg;
            if (sat_reg || sum > SUM_W'(cap_fp)) refilled = cap_fp;
            else refilled = sum[LEVEL_W-1:0];
        end

        new_level    = refilled;
        new_inflight = inflight_reg;
        new_status   = ST_OK;
        wr_en        = 1'b0;

        if (op_reg == CMD_RELEASE) begin
            new_level  = level_reg;
            new_last   = last_reg;
            new_tokens = level_reg;
            if (!hit_reg) begin
                new_status = ST_IGNORED;
                new_tokens = '0;
            end else begin
                wr_en = cmd.writeback;
                if (inflight_reg != '0) new_inflight = inflight_reg - 1'b1;
            end
        end else begin
            wr_en = cmd.writeback;
            if (refilled >= TOKEN_ONE) begin
                // token is spent even when the concurrency cap turns the request away
                new_level = refilled - TOKEN_ONE;
                if (inflight_reg >= conc_reg) new_status = ST_CAP;
                else new_inflight = inflight_reg + 1'b1;
            end else begin
                new_status = ST_EXHAUSTED;
            end
            new_tokens = new_level;
        end

        wr_data = {new_level, new_last, new_inflight};
    end

    always_ff @(posedge aclk) begin
        if (cmd.writeback) begin
            out_status <= new_status;
            out_tokens <= new_tokens;
        end
    end

endmodule

### verif/tb_tenant_token_bucket_limiter.sv
module tb_tenant_token_bucket_limiter;
    import ttbl_pkg::*;

    localparam int TIME_W     = 48;
    localparam int NUM_TENANT = 1 << TENANT_W;
    localparam int STALL_MAX  = 2000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  tokens_left;
    } outcome_t;

    // Tracks the per-tenant buckets and predicts one outcome per request beat.
    class admission_scoreboard;
        logic [CAP_W-1:0]   capacity;
        logic [RATE_W-1:0]  rate;
        logic [CONC_W-1:0]  max_conc;
        bit                 known    [NUM_TENANT];
        logic [LEVEL_W-1:0] level    [NUM_TENANT];
        logic [TIME_W-1:0]  stamp    [NUM_TENANT];
        logic [CONC_W-1:0]  inflight [NUM_TENANT];
        outcome_t           outcome_q[$];
        int                 errors;

        function new();
            capacity = CAPACITY_RST;
            rate     = RATE_RST;
            max_conc = MAX_CONC_RST;
            errors   = 0;
            foreach (known[i]) known[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CAPACITY: capacity = data[CAP_W-1:0];
                CFG_RATE:     rate     = data[RATE_W-1:0];
                CFG_MAX_CONC: max_conc = data[CONC_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic cmd, logic [TENANT_W-1:0] t, logic [TIME_W-1:0] now);
            logic [LEVEL_W-1:0] full;
            logic [TIME_W-1:0]  elapsed;
            logic [63:0]        gain;
            logic [63:0]        sum;
            outcome_t           res;
            full = {capacity, {TOKEN_SHIFT{1'b0}}};
            if (cmd == CMD_RELEASE) begin
                if (!known[t]) begin
                    res.status      = ST_IGNORED;
                    res.tokens_left = '0;
                end else begin
                    if (inflight[t] != 0) inflight[t] = inflight[t] - 1'b1;
                    res.status      = ST_OK;
                    res.tokens_left = level[t];
                end
            end else begin
                if (!known[t]) begin
                    known[t]    = 1'b1;
                    level[t]    = full;
                    stamp[t]    = now;
                    inflight[t] = '0;
                end
                elapsed = now - stamp[t];
                if (elapsed != 0 && rate != 0) begin
                    if (elapsed >= (48'd1 << SAT_SHIFT))
                        gain = 64'd1 << 47;
                    else
                        gain = 64'(elapsed) * 64'(rate);
                    sum = 64'(level[t]) + gain;
                    if (sum > 64'(full)) sum = 64'(full);
                    level[t] = sum[LEVEL_W-1:0];
                    stamp[t] = now;
                end
                if (level[t] >= TOKEN_ONE) begin
                    level[t] = level[t] - TOKEN_ONE;
                    // token stays spent even when the cap turns the request away
                    if (inflight[t] >= max_conc) begin
                        res.status = ST_CAP;
                    end else begin
                        inflight[t] = inflight[t] + 1'b1;
                        res.status  = ST_OK;
                    end
                end else begin
                    res.status = ST_EXHAUSTED;
                end
                res.tokens_left = level[t];
            end
            outcome_q = {outcome_q, res};
        endfunction

        function void check_outcome(logic [STATUS_W-1:0] status, logic [LEVEL_W-1:0] tokens);
            outcome_t exp_res;
            if (outcome_q.size() == 0) begin
                $error("result beat with nothing expected: status %0d tokens_left %0d",
                       status, tokens);
                errors++;
                return;
            end
            exp_res = outcome_q.pop_front();
            if (status !== exp_res.status) begin
                $error("status expected %0d actual %0d", exp_res.status, status);
                errors++;
            end
            if (tokens !== exp_res.tokens_left) begin
                $error("tokens_left expected %0d actual %0d", exp_res.tokens_left, tokens);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           s_tdata;   // [7:0] tenant, [55:8] now
    logic                  s_tuser;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // [25:0] tokens_left, zero pad
    logic [STATUS_W-1:0]   m_tuser;   // [1:0] status
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    admission_scoreboard sb;
    bit                  no_idle;
    logic [TIME_W-1:0]   tick;
    int                  stall_cycles;

    always #2 aclk = ~aclk;

    tenant_token_bucket_limiter #(
        .TENANTS   (NUM_TENANT),
        .TIME_BITS (TIME_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[7:0], s_tdata[55:8]);
            if (m_tvalid && m_tready)
                sb.check_outcome(m_tuser, m_tdata[LEVEL_W-1:0]);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [TIME_W-1:0] rand_stamp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_request(input logic cmd, input logic [TENANT_W-1:0] tenant,
                                input logic [TIME_W-1:0] now);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, tenant};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender off until every outstanding result beat is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_config(input int cap, input int rate, input int conc);
        drain();
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(CFG_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_MAX_CONC, CFG_DATA_W'(conc));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int items);
        logic [TENANT_W-1:0] hot [6];
        logic [TENANT_W-1:0] tenant;
        logic [TIME_W-1:0]   now;
        logic                cmd;
        int                  pick;
        foreach (hot[i]) hot[i] = TENANT_W'($urandom_range(NUM_TENANT - 1));
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) == 0) drain();
            if ($urandom_range(99) < 80) begin
                // steady traffic on a few tenants with a slowly moving clock
                tenant = hot[$urandom_range(5)];
                cmd    = ($urandom_range(99) < 40) ? CMD_RELEASE : CMD_ACQUIRE;
                pick   = $urandom_range(99);
                if (pick < 40)
                    tick = tick;
                else if (pick < 85)
                    tick = tick + TIME_W'($urandom_range(1, 3));
                else if (pick < 97)
                    tick = tick + TIME_W'($urandom_range(1, 5000));
                else
                    tick = tick + (48'd1 << SAT_SHIFT) + TIME_W'($urandom_range(0, 1 << 20));
                now = tick;
            end else begin
                tenant = TENANT_W'($urandom_range(NUM_TENANT - 1));
                cmd    = logic'($urandom_range(1));
                if ($urandom_range(1) == 1)
                    now = rand_stamp();
                else
                    now = tick - TIME_W'($urandom_range(1, 100));
            end
            send_request(cmd, tenant, now);
        end
    endtask

    initial begin
        sb           = new();
        no_idle      = 1'b0;
        stall_cycles = 0;
        tick         = '0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: unknown release, wrap, no elapsed time, huge elapsed time
        send_request(CMD_RELEASE, 8'h00, 48'h0);
        send_request(CMD_ACQUIRE, 8'hFF, 48'hFFFF_FFFF_FFFE);
        send_request(CMD_RELEASE, 8'hFF, 48'hFFFF_FFFF_FFFE);
        send_request(CMD_RELEASE, 8'hFF, 48'hFFFF_FFFF_FFFE);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h0000_0000_0001);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h0000_0000_0001);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h8000_0000_0001);
        send_request(CMD_ACQUIRE, 8'h55, 48'h5555_5555_5555);
        send_request(CMD_ACQUIRE, 8'hAA, 48'hAAAA_AAAA_AAAA);

        // one-token bucket, no refill, no concurrency allowed
        apply_config(1, 0, 0);
        send_request(CMD_ACQUIRE, 8'h10, 48'h100);
        send_request(CMD_ACQUIRE, 8'h10, 48'h200);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h8000_0000_0100);

        // empty bucket; refill clamps a stale high level down
        apply_config(0, 1, 16);
        send_request(CMD_ACQUIRE, 8'h20, 48'h300);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h8000_0000_0200);

        apply_config(65535, 1048575, 65535);
        send_request(CMD_ACQUIRE, 8'h30, 48'h0);
        send_request(CMD_ACQUIRE, 8'hFF, 48'h8000_0000_0300);
        send_request(CMD_ACQUIRE, 8'h30, 48'hFFFF_FFFF_FFFF);

        apply_config(100, 1024, 2);
        send_request(CMD_ACQUIRE, 8'h40, 48'h1000);
        send_request(CMD_ACQUIRE, 8'h40, 48'h1000);
        send_request(CMD_ACQUIRE, 8'h40, 48'h1000);
        send_request(CMD_RELEASE, 8'h40, 48'h1000);
        send_request(CMD_ACQUIRE, 8'h40, 48'h1001);
        send_request(CMD_RELEASE, 8'hC3, 48'h1001);

        tick = 48'hFFFF_FFFF_F000;
        apply_config(4, 300, 3);
        run_phase(225);

        tick = rand_stamp();
        apply_config(65535, 1048575, 65535);
        run_phase(225);

        apply_config(1, 512, 1);
        run_phase(225);

        no_idle = 1'b1;
        apply_config(100, 1024, 16);
        run_phase(225);
        no_idle = 1'b0;

        repeat (3) begin
            tick = rand_stamp();
            apply_config($urandom_range(1, 12), $urandom_range(0, 3000), $urandom_range(0, 6));
            run_phase(225);
        end

        apply_config($urandom_range(1, 65535), $urandom_range(0, 1048575),
                     $urandom_range(0, 65535));
        run_phase(225);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.outcome_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
